// ===== hdl/tsli_pkg.sv =====
// Shared types and constants for the time series linear interpolator.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package tsli_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  localparam int TIME_W  = 32;
  localparam int STEER_W = 16;
  localparam int PEDAL_W = 15;
  localparam int FRAC_W  = 17;
  localparam int DIV_STEPS = 17;
  localparam int DIV_CNT_W = 5;
  localparam int DIFF_W  = 17;
  localparam int PROD_W  = FRAC_W + 1 + DIFF_W;

  typedef struct packed {
    logic [TIME_W-1:0]         time_value;
    logic signed [STEER_W-1:0] steering;
    logic [PEDAL_W-1:0]        throttle;
    logic [PEDAL_W-1:0]        braking;
  } entry_t;

  typedef enum logic [1:0] {
    RD_MID   = 2'd0,
    RD_RIGHT = 2'd1,
    RD_LEFT  = 2'd2
  } rd_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EMPTY,
    ST_SRCH_CHK,
    ST_SRCH_CMP,
    ST_READ_R,
    ST_READ_L,
    ST_CAP_L,
    ST_DIV,
    ST_MUL,
    ST_OUT_EDGE,
    ST_OUT_INTERP
  } state_t;

  typedef struct packed {
    logic    accept;
    logic    search_init;
    logic    search_update;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    capture_r;
    logic    div_init;
    logic    div_step;
    logic    mul;
    logic    load_empty;
    logic    load_edge;
    logic    load_interp;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_query;
    logic table_empty;
    logic search_done;
    logic edge_hit;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/tsli_ctrl.sv =====
// Sequencing state machine for the time series linear interpolator.
// Depends on tsli_pkg; drives the datapath through tsli_pkg::ctrl_cmd_t.
`default_nettype none

module tsli_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire tsli_pkg::dp_status_t dp_status,
  output tsli_pkg::ctrl_cmd_t       dp_cmd
);

  tsli_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsli_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    dp_cmd = '0;
    dp_cmd.rd_sel = tsli_pkg::RD_MID;
    in_stall = 1'b1;
    unique case (state)
      tsli_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          dp_cmd.accept = 1'b1;
          if (dp_status.is_query) begin
            if (dp_status.table_empty) begin
              state_next = tsli_pkg::ST_EMPTY;
            end else begin
              dp_cmd.search_init = 1'b1;
              state_next = tsli_pkg::ST_SRCH_CHK;
            end
          end
        end
      end
      tsli_pkg::ST_EMPTY: begin
        if (dp_status.out_free) begin
          dp_cmd.load_empty = 1'b1;
          state_next = tsli_pkg::ST_IDLE;
        end
      end
      tsli_pkg::ST_SRCH_CHK: begin
        if (dp_status.search_done) begin
          state_next = tsli_pkg::ST_READ_R;
        end else begin
          dp_cmd.rd_en = 1'b1;
          dp_cmd.rd_sel = tsli_pkg::RD_MID;
          state_next = tsli_pkg::ST_SRCH_CMP;
        end
      end
      tsli_pkg::ST_SRCH_CMP: begin
        dp_cmd.search_update = 1'b1;
        state_next = tsli_pkg::ST_SRCH_CHK;
      end
      tsli_pkg::ST_READ_R: begin
        dp_cmd.rd_en = 1'b1;
        dp_cmd.rd_sel = tsli_pkg::RD_RIGHT;
        state_next = tsli_pkg::ST_READ_L;
      end
      tsli_pkg::ST_READ_L: begin
        dp_cmd.capture_r = 1'b1;
        if (dp_status.edge_hit) begin
          state_next = tsli_pkg::ST_OUT_EDGE;
        end else begin
          dp_cmd.rd_en = 1'b1;
          dp_cmd.rd_sel = tsli_pkg::RD_LEFT;
          state_next = tsli_pkg::ST_CAP_L;
        end
      end
      tsli_pkg::ST_CAP_L: begin
        dp_cmd.div_init = 1'b1;
        state_next = tsli_pkg::ST_DIV;
      end
      tsli_pkg::ST_DIV: begin
        if (dp_status.div_done) begin
          state_next = tsli_pkg::ST_MUL;
        end else begin
          dp_cmd.div_step = 1'b1;
        end
      end
      tsli_pkg::ST_MUL: begin
        dp_cmd.mul = 1'b1;
        state_next = tsli_pkg::ST_OUT_INTERP;
      end
      tsli_pkg::ST_OUT_EDGE: begin
        if (dp_status.out_free) begin
          dp_cmd.load_edge = 1'b1;
          state_next = tsli_pkg::ST_IDLE;
        end
      end
      tsli_pkg::ST_OUT_INTERP: begin
        if (dp_status.out_free) begin
          dp_cmd.load_interp = 1'b1;
          state_next = tsli_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tsli_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/tsli_datapath.sv =====
// Datapath of the time series linear interpolator: breakpoint memory, search
// bounds, serial fraction divider, channel multipliers and output register.
// Depends on tsli_pkg; commanded by tsli_ctrl.
`default_nettype none

module tsli_datapath #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire tsli_pkg::ctrl_cmd_t                   dp_cmd,
  output tsli_pkg::dp_status_t                       dp_status,
  input  wire logic [1:0]                            cmd,
  input  wire logic [tsli_pkg::TIME_W-1:0]           time_value,
  input  wire logic signed [tsli_pkg::STEER_W-1:0]   steering_in,
  input  wire logic [tsli_pkg::PEDAL_W-1:0]          throttle_in,
  input  wire logic [tsli_pkg::PEDAL_W-1:0]          braking_in,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [tsli_pkg::STEER_W-1:0]        steering_out,
  output logic [tsli_pkg::PEDAL_W-1:0]               throttle_out,
  output logic [tsli_pkg::PEDAL_W-1:0]               braking_out,
  output logic                                       status
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int TW = tsli_pkg::TIME_W;
  localparam int PW = tsli_pkg::PROD_W;

  tsli_pkg::entry_t mem [TABLE_DEPTH];
  tsli_pkg::entry_t rdata;
  tsli_pkg::entry_t entry_r;

  logic [CW-1:0] count;
  logic [TW-1:0] last_time;
  logic [TW-1:0] qtime;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [CW-1:0] mid;
  logic [CW-1:0] rd_idx;
  logic          append_ok;
  logic          at_end;

  logic [TW:0]   rem;
  logic [TW-1:0] span;
  logic [tsli_pkg::FRAC_W-1:0] frac;
  logic [tsli_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [TW+1:0] div_shift;
  logic          div_ge;

  logic signed [tsli_pkg::DIFF_W-1:0] diff_st;
  logic signed [tsli_pkg::DIFF_W-1:0] diff_th;
  logic signed [tsli_pkg::DIFF_W-1:0] diff_br;
  logic signed [tsli_pkg::FRAC_W:0]   frac_s;
  logic signed [PW-1:0] prod_st;
  logic signed [PW-1:0] prod_th;
  logic signed [PW-1:0] prod_br;
  logic signed [PW-1:0] step_st;
  logic signed [PW-1:0] step_th;
  logic signed [PW-1:0] step_br;
  logic signed [tsli_pkg::STEER_W-1:0] base_st;
  logic [tsli_pkg::PEDAL_W-1:0]        base_th;
  logic [tsli_pkg::PEDAL_W-1:0]        base_br;

  assign mid = lo + ((hi - lo) >> 1);
  assign at_end = (lo == count);
  assign append_ok = dp_cmd.accept && (cmd == tsli_pkg::CMD_APPEND)
                     && (count < CW'(TABLE_DEPTH))
                     && ((count == '0) || (time_value > last_time));

  always_comb begin
    unique case (dp_cmd.rd_sel)
      tsli_pkg::RD_MID:   rd_idx = mid;
      tsli_pkg::RD_RIGHT: rd_idx = at_end ? (lo - CW'(1)) : lo;
      tsli_pkg::RD_LEFT:  rd_idx = lo - CW'(1);
      default:            rd_idx = mid;
    endcase
  end

  always_ff @(posedge clk) begin
    if (append_ok) begin
      mem[count[IW-1:0]] <= '{time_value: time_value, steering: steering_in,
                              throttle: throttle_in, braking: braking_in};
    end
    if (dp_cmd.rd_en) begin
      rdata <= mem[rd_idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (dp_cmd.accept && (cmd == tsli_pkg::CMD_CLEAR)) begin
      count <= '0;
    end else if (append_ok) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (append_ok) begin
      last_time <= time_value;
    end
    if (dp_cmd.accept) begin
      qtime <= time_value;
    end
    if (dp_cmd.search_init) begin
      lo <= '0;
      hi <= count;
    end else if (dp_cmd.search_update) begin
      if (rdata.time_value < qtime) begin
        lo <= mid + CW'(1);
      end else begin
        hi <= mid;
      end
    end
    if (dp_cmd.capture_r) begin
      entry_r <= rdata;
    end
  end

  assign div_shift = (div_cnt == '0) ? {1'b0, rem} : {rem, 1'b0};
  assign div_ge = (div_shift >= {2'b00, span});

  always_ff @(posedge clk) begin
    if (dp_cmd.div_init) begin
      rem     <= {1'b0, qtime - rdata.time_value};
      span    <= entry_r.time_value - rdata.time_value;
      div_cnt <= '0;
      frac    <= '0;
      base_st <= rdata.steering;
      base_th <= rdata.throttle;
      base_br <= rdata.braking;
      diff_st <= {entry_r.steering[tsli_pkg::STEER_W-1], entry_r.steering}
                 - {rdata.steering[tsli_pkg::STEER_W-1], rdata.steering};
      diff_th <= {2'b00, entry_r.throttle} - {2'b00, rdata.throttle};
      diff_br <= {2'b00, entry_r.braking} - {2'b00, rdata.braking};
    end else if (dp_cmd.div_step) begin
      rem     <= div_ge ? (TW+1)'(div_shift - {2'b00, span}) : div_shift[TW:0];
      frac    <= {frac[tsli_pkg::FRAC_W-2:0], div_ge};
      div_cnt <= div_cnt + tsli_pkg::DIV_CNT_W'(1);
    end
  end

  assign frac_s = {1'b0, frac};
  assign prod_st = frac_s * diff_st;
  assign prod_th = frac_s * diff_th;
  assign prod_br = frac_s * diff_br;

  always_ff @(posedge clk) begin
    if (dp_cmd.mul) begin
      step_st <= prod_st >>> 16;
      step_th <= prod_th >>> 16;
      step_br <= prod_br >>> 16;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.load_empty || dp_cmd.load_edge || dp_cmd.load_interp) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load_empty) begin
      steering_out <= '0;
      throttle_out <= '0;
      braking_out  <= '0;
      status       <= 1'b1;
    end else if (dp_cmd.load_edge) begin
      steering_out <= entry_r.steering;
      throttle_out <= entry_r.throttle;
      braking_out  <= entry_r.braking;
      status       <= 1'b0;
    end else if (dp_cmd.load_interp) begin
      steering_out <= base_st + step_st[tsli_pkg::STEER_W-1:0];
      throttle_out <= base_th + step_th[tsli_pkg::PEDAL_W-1:0];
      braking_out  <= base_br + step_br[tsli_pkg::PEDAL_W-1:0];
      status       <= 1'b0;
    end
  end

  always_comb begin
    dp_status.is_query    = (cmd == tsli_pkg::CMD_QUERY);
    dp_status.table_empty = (count == '0);
    dp_status.search_done = (lo == hi);
    dp_status.edge_hit    = (lo == '0) || at_end;
    dp_status.div_done    = (div_cnt == tsli_pkg::DIV_CNT_W'(tsli_pkg::DIV_STEPS));
    dp_status.out_free    = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

// ===== hdl/time_series_linear_interpolator.sv =====
// Piecewise linear interpolator over a table of up to TABLE_DEPTH breakpoints,
// each a Q16.16 time with steering, throttle and braking values. A clear or an
// append beat leaves the block idle and returns nothing; appends to a full
// table or with a time not above the last one are dropped. A query beat holds
// the input for its whole run: on an empty table it returns status 1; else a
// binary search over the single-port breakpoint memory takes at most
// clog2(TABLE_DEPTH+1) halvings, each a read and a compare, then come the
// end-point reads and, in the interior, the bit-serial Q1.16 fraction divider
// and a multiply. The length of a query is set by the memory port in the
// search and by the divider. The result sits in an output register, so the
// next beat is taken while it waits.
// Depends on tsli_pkg, tsli_ctrl and tsli_datapath.
`default_nettype none

module time_series_linear_interpolator #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [1:0]                          cmd,
  input  wire logic [tsli_pkg::TIME_W-1:0]         time_value,
  input  wire logic signed [tsli_pkg::STEER_W-1:0] steering_in,
  input  wire logic [tsli_pkg::PEDAL_W-1:0]        throttle_in,
  input  wire logic [tsli_pkg::PEDAL_W-1:0]        braking_in,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [tsli_pkg::STEER_W-1:0]      steering_out,
  output logic [tsli_pkg::PEDAL_W-1:0]             throttle_out,
  output logic [tsli_pkg::PEDAL_W-1:0]             braking_out,
  output logic                                     status
);

  tsli_pkg::ctrl_cmd_t  dp_cmd;
  tsli_pkg::dp_status_t dp_status;

  tsli_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd)
  );

  tsli_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .dp_cmd       (dp_cmd),
    .dp_status    (dp_status),
    .cmd          (cmd),
    .time_value   (time_value),
    .steering_in  (steering_in),
    .throttle_in  (throttle_in),
    .braking_in   (braking_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .steering_out (steering_out),
    .throttle_out (throttle_out),
    .braking_out  (braking_out),
    .status       (status)
  );

endmodule

`default_nettype wire

// ===== sim/tsli_interp_checker.sv =====
// Scoreboard for the time series linear interpolator: keeps its own copy of the
// breakpoint table, predicts every query result and compares the result beats.
// Depends on tsli_pkg.
module tsli_interp_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  input  wire logic                                in_stall,
  input  wire logic [1:0]                          cmd,
  input  wire logic [tsli_pkg::TIME_W-1:0]         time_value,
  input  wire logic signed [tsli_pkg::STEER_W-1:0] steering_in,
  input  wire logic [tsli_pkg::PEDAL_W-1:0]        throttle_in,
  input  wire logic [tsli_pkg::PEDAL_W-1:0]        braking_in,
  input  wire logic                                out_valid,
  input  wire logic                                out_stall,
  input  wire logic signed [tsli_pkg::STEER_W-1:0] steering_out,
  input  wire logic [tsli_pkg::PEDAL_W-1:0]        throttle_out,
  input  wire logic [tsli_pkg::PEDAL_W-1:0]        braking_out,
  input  wire logic                                status,
  output int                                       fail_count,
  output int                                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [tsli_pkg::STEER_W-1:0] steering;
    logic [tsli_pkg::PEDAL_W-1:0]        throttle;
    logic [tsli_pkg::PEDAL_W-1:0]        braking;
    logic                                status;
  } sample_t;

  logic [tsli_pkg::TIME_W-1:0]         bp_time     [TABLE_DEPTH];
  logic signed [tsli_pkg::STEER_W-1:0] bp_steer    [TABLE_DEPTH];
  logic [tsli_pkg::PEDAL_W-1:0]        bp_throttle [TABLE_DEPTH];
  logic [tsli_pkg::PEDAL_W-1:0]        bp_braking  [TABLE_DEPTH];
  int                                  bp_count;
  sample_t                             expected_q[$];

  initial begin
    fail_count = 0;
    pending = 0;
    bp_count = 0;
  end

  // Floor division by 65536 is an arithmetic shift of the signed product.
  function automatic longint lerp(longint left, longint right, longint frac);
    longint prod;
    prod = frac * (right - left);
    return left + (prod >>> 16);
  endfunction

  function automatic sample_t interpolate(logic [tsli_pkg::TIME_W-1:0] t);
    sample_t    s;
    int         r;
    int         l;
    logic [63:0] num;
    logic [63:0] span;
    longint     frac;
    s = '0;
    if (bp_count == 0) begin
      s.status = 1'b1;
      return s;
    end
    if (t <= bp_time[0]) begin
      r = 0;
    end else if (t >= bp_time[bp_count-1]) begin
      r = bp_count - 1;
    end else begin
      r = -1;
    end
    if (r >= 0) begin
      s.steering = bp_steer[r];
      s.throttle = bp_throttle[r];
      s.braking  = bp_braking[r];
      return s;
    end
    r = 1;
    while (bp_time[r] < t) r++;
    l = r - 1;
    num  = {16'd0, t - bp_time[l], 16'd0};
    span = {32'd0, bp_time[r] - bp_time[l]};
    frac = longint'(num / span);
    s.steering = tsli_pkg::STEER_W'(lerp(longint'(bp_steer[l]), longint'(bp_steer[r]), frac));
    s.throttle = tsli_pkg::PEDAL_W'(lerp(longint'(bp_throttle[l]),
                                         longint'(bp_throttle[r]), frac));
    s.braking  = tsli_pkg::PEDAL_W'(lerp(longint'(bp_braking[l]),
                                         longint'(bp_braking[r]), frac));
    return s;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    sample_t want;
    if (rst) begin
      bp_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with no query waiting, expected none, got %0d %0d %0d %0d",
                   $time, steering_out, throttle_out, braking_out, status);
        end else begin
          want = expected_q.pop_front();
          check_field("steering", longint'($signed(want.steering)), longint'(steering_out));
          check_field("throttle", longint'(want.throttle), longint'(throttle_out));
          check_field("braking", longint'(want.braking), longint'(braking_out));
          check_field("status", longint'(want.status), longint'(status));
        end
      end
      if (in_valid && !in_stall) begin
        case (cmd)
          tsli_pkg::CMD_CLEAR: begin
            bp_count = 0;
          end
          tsli_pkg::CMD_APPEND: begin
            if (bp_count < TABLE_DEPTH &&
                (bp_count == 0 || time_value > bp_time[bp_count-1])) begin
              bp_time[bp_count]     = time_value;
              bp_steer[bp_count]    = steering_in;
              bp_throttle[bp_count] = throttle_in;
              bp_braking[bp_count]  = braking_in;
              bp_count++;
            end
          end
          tsli_pkg::CMD_QUERY: begin
            expected_q = {expected_q, interpolate(time_value)};
          end
          default: begin
          end
        endcase
      end
      pending = expected_q.size();
    end
  end

endmodule

// ===== sim/time_series_linear_interpolator_tb.sv =====
// Top of the interpolator testbench: drives directed and random command beats
// in bursts, stalls the result channel and gives the verdict.
// Depends on tsli_pkg, time_series_linear_interpolator and tsli_interp_checker.
module time_series_linear_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         TABLE_DEPTH  = 64;
  localparam int         RANDOM_BEATS = 950;
  localparam int         CYCLE_LIMIT  = 600000;
  localparam int         DRAIN_CYCLES = 64;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;

  logic                                clk;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [1:0]                          cmd = tsli_pkg::CMD_CLEAR;
  logic [tsli_pkg::TIME_W-1:0]         time_value = '0;
  logic signed [tsli_pkg::STEER_W-1:0] steering_in = '0;
  logic [tsli_pkg::PEDAL_W-1:0]        throttle_in = '0;
  logic [tsli_pkg::PEDAL_W-1:0]        braking_in = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [tsli_pkg::STEER_W-1:0] steering_out;
  logic [tsli_pkg::PEDAL_W-1:0]        throttle_out;
  logic [tsli_pkg::PEDAL_W-1:0]        braking_out;
  logic                                status;

  int                          fail_count;
  int                          pending;
  int                          cycle_count = 0;
  int                          beats_sent = 0;
  int                          burst_left = 0;
  int                          random_goal;
  int                          stall_mode = 0;
  int                          stall_phase = 0;
  logic [tsli_pkg::TIME_W-1:0] bp_times[$];

  time_series_linear_interpolator #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .time_value(time_value),
    .steering_in(steering_in),
    .throttle_in(throttle_in),
    .braking_in(braking_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .steering_out(steering_out),
    .throttle_out(throttle_out),
    .braking_out(braking_out),
    .status(status)
  );

  tsli_interp_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .time_value(time_value),
    .steering_in(steering_in),
    .throttle_in(throttle_in),
    .braking_in(braking_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .steering_out(steering_out),
    .throttle_out(throttle_out),
    .braking_out(braking_out),
    .status(status),
    .fail_count(fail_count),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // The result channel switches between free running, light and heavy stalling.
  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_mode  <= $urandom_range(0, 2);
      stall_phase <= $urandom_range(20, 200);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send_beat(input logic [1:0] c, input logic [tsli_pkg::TIME_W-1:0] t,
                           input logic [tsli_pkg::STEER_W-1:0] st,
                           input logic [tsli_pkg::PEDAL_W-1:0] th,
                           input logic [tsli_pkg::PEDAL_W-1:0] br);
    in_valid    <= 1'b1;
    cmd         <= c;
    time_value  <= t;
    steering_in <= st;
    throttle_in <= th;
    braking_in  <= br;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  function automatic logic [tsli_pkg::STEER_W-1:0] rand_steer();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return tsli_pkg::STEER_W'($urandom);
    endcase
  endfunction

  function automatic logic [tsli_pkg::PEDAL_W-1:0] rand_pedal();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return tsli_pkg::PEDAL_W'($urandom);
    endcase
  endfunction

  function automatic logic [tsli_pkg::TIME_W-1:0] pick_query_time();
    int k;
    if (bp_times.size() == 0) return $urandom;
    k = $urandom_range(0, bp_times.size() - 1);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return $urandom;
      3: return bp_times[k];
      4: return bp_times[k] + 1;
      5: return bp_times[k] - 1;
      default: begin
        if (k + 1 < bp_times.size()) begin
          return bp_times[k] + $urandom_range(0, bp_times[k+1] - bp_times[k]);
        end
        return bp_times[k] + $urandom;
      end
    endcase
  endfunction

  task automatic send_query(input logic [tsli_pkg::TIME_W-1:0] t);
    send_beat(tsli_pkg::CMD_QUERY, t, rand_steer(), rand_pedal(), rand_pedal());
  endtask

  // A clear, a rising run of breakpoints with queries mixed in, then more queries.
  task automatic run_table_sequence();
    int                          n_points;
    logic [tsli_pkg::TIME_W-1:0] t_next;
    logic [tsli_pkg::TIME_W-1:0] step;
    n_points = ($urandom_range(0, 7) == 0) ? $urandom_range(TABLE_DEPTH - 2, TABLE_DEPTH + 8)
                                           : $urandom_range(1, 12);
    bp_times.delete();
    send_beat(tsli_pkg::CMD_CLEAR, $urandom, rand_steer(), rand_pedal(), rand_pedal());
    t_next = ($urandom_range(0, 1) == 0) ? tsli_pkg::TIME_W'($urandom_range(0, 255))
                                         : $urandom_range(0, 32'h4000_0000);
    for (int i = 0; i < n_points; i++) begin
      send_beat(tsli_pkg::CMD_APPEND, t_next, rand_steer(), rand_pedal(), rand_pedal());
      bp_times = {bp_times, t_next};
      case ($urandom_range(0, 3))
        0: step = 1;
        1: step = $urandom_range(1, 32'h0001_0000);
        2: step = $urandom_range(1, 32'h0100_0000);
        default: step = $urandom_range(1, 32'h0400_0000);
      endcase
      if (t_next > '1 - step) begin
        t_next = '1;
      end else begin
        t_next += step;
      end
      if ($urandom_range(0, 2) == 0) send_query(pick_query_time());
    end
    repeat ($urandom_range(2, 8)) send_query(pick_query_time());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_query(32'h0000_0000);
    send_beat(CMD_UNUSED, 32'h0001_0000, 16'h7FFF, 15'h7FFF, 15'h7FFF);
    send_beat(tsli_pkg::CMD_APPEND, 32'h0001_0000, 16'h8000, 15'h0000, 15'h7FFF);
    send_query(32'h0000_0000);
    send_query(32'hFFFF_FFFF);
    send_beat(tsli_pkg::CMD_APPEND, 32'h0001_0000, 16'h1111, 15'h1111, 15'h1111);
    send_beat(tsli_pkg::CMD_APPEND, 32'h0000_8000, 16'h2222, 15'h2222, 15'h2222);
    send_beat(tsli_pkg::CMD_APPEND, 32'h0003_0000, 16'h7FFF, 15'h7FFF, 15'h0000);
    send_beat(tsli_pkg::CMD_APPEND, 32'hFFFF_FFFF, 16'hFFFF, 15'h5555, 15'h2AAA);
    send_query(32'h0001_0000);
    send_query(32'h0001_0001);
    send_query(32'h0002_0000);
    send_query(32'h0002_FFFF);
    send_query(32'h0003_0000);
    send_query(32'h8000_0000);
    send_query(32'hFFFF_FFFE);
    send_query(32'hFFFF_FFFF);
    send_beat(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF);
    send_beat(tsli_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF);
    send_query(32'h0002_0000);
    send_beat(tsli_pkg::CMD_APPEND, 32'h0000_0000, 16'h1234, 15'h0ABC, 15'h7000);
    send_beat(tsli_pkg::CMD_APPEND, 32'h0000_0001, 16'hEDCC, 15'h7543, 15'h0001);
    send_query(32'h0000_0000);
    send_query(32'h0000_0001);

    random_goal = beats_sent + RANDOM_BEATS;
    while (beats_sent < random_goal) begin
      if ($urandom_range(0, 9) < 8) begin
        run_table_sequence();
      end else begin
        send_beat(2'($urandom_range(0, 3)), $urandom, rand_steer(), rand_pedal(), rand_pedal());
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
